// File: hdl/pip_pkg.sv
// Package for the point-in-polygon test: sizes, command and status codes,
// payload and control structs. No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

  localparam int MAX_VERTICES = 64;
  localparam int COORD_WIDTH  = 16;
  localparam int RAY_X_INT    = -100000;

  localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int ADDR_W = $clog2(MAX_VERTICES);
  // edge and point differences
  localparam int DW = COORD_WIDTH + 1;
  // ray point minus vertex x, down to RAY_X_INT - 2^(COORD_WIDTH-1) + 1
  localparam int RW = (COORD_WIDTH + 2 > 19) ? COORD_WIDTH + 2 : 19;
  // cross product difference
  localparam int PW = DW + RW + 1;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [1:0]                    command;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
  } pip_in_t;

  typedef struct packed {
    logic             inside_res;
    logic             on_boundary;
    logic [1:0]       status;
    logic [CNT_W-1:0] vertex_count;
  } pip_out_t;

  typedef struct packed {
    logic              accept;
    logic              issue;
    logic              first;
    logic [ADDR_W-1:0] addr;
    logic              load;
  } pip_ctl_t;

  typedef struct packed {
    logic             walk_req;
    logic             pipe_busy;
    logic [CNT_W-1:0] count;
  } pip_stat_t;

endpackage

// File: hdl/pip_ctrl.sv
// Controller for the point-in-polygon test: accepts items, sequences the
// vertex reads of a query and waits for the edge pipeline. Uses pip_pkg.
`timescale 1ns / 1ps

module pip_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pip_pkg::pip_stat_t stat,
  output pip_pkg::pip_ctl_t  ctl
);
  import pip_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_WALK  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ctl        = '0;
    busy       = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy       = 1'b0;
        ctl.accept = start;
        idx_nxt    = '0;
        if (start && stat.walk_req) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        ctl.issue = 1'b1;
        ctl.first = (idx_r == '0);
        // one extra read of vertex 0 closes the polygon
        ctl.addr  = (idx_r == stat.count) ? '0 : idx_r[ADDR_W-1:0];
        if (idx_r == stat.count) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          ctl.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// File: hdl/pip_dp.sv
// Datapath for the point-in-polygon test: vertex store, edge pipeline with
// exact cross products, crossing and boundary accumulators, result register.
// Uses pip_pkg.
`timescale 1ns / 1ps

module pip_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  pip_pkg::pip_in_t   in_data,
  input  pip_pkg::pip_ctl_t  ctl,
  output pip_pkg::pip_stat_t stat,
  output logic               out_strobe,
  output pip_pkg::pip_out_t  out_data
);
  import pip_pkg::*;

  localparam logic signed [RW-1:0] RAY_X = RW'(RAY_X_INT);

  logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, py_r;
  logic                          wr_en;
  logic                          not_full;

  // read stage
  logic                          r_vld_r, r_first_r;
  logic signed [COORD_WIDTH-1:0] rx_r, ry_r;
  logic signed [COORD_WIDTH-1:0] pvx_r, pvy_r;
  // edge stage
  logic                          e_vld_r;
  logic signed [COORD_WIDTH-1:0] esx_r, esy_r, eex_r, eey_r;
  // difference stage
  logic                          d_vld_r, d_bx_r, d_by_r, d_yr_r;
  logic signed [DW-1:0]          dx_r, dy_r, dpx_r, dpy_r;
  logic signed [RW-1:0]          drx_r;
  // product stage
  logic                          p_vld_r, p_bx_r, p_by_r, p_yr_r;
  logic signed [2*DW-1:0]        p1_r, p2_r;
  logic signed [DW+RW-1:0]       p3_r;
  // accumulators
  logic                          bnd_r, crs_r;

  logic signed [COORD_WIDTH-1:0] xlo, xhi, ylo, yhi;
  logic signed [PW-1:0]          cp_pt, cp_ray;
  logic                          pt_zero, pt_neg, ray_zero, ray_neg, side_diff;

  pip_out_t imm;

  assign not_full = (count_r < CNT_W'(MAX_VERTICES));
  assign wr_en    = ctl.accept && (in_data.command == CMD_APPEND) && not_full;

  assign stat.walk_req  = (in_data.command == CMD_QUERY) && (count_r >= CNT_W'(3));
  assign stat.pipe_busy = r_vld_r || e_vld_r || d_vld_r || p_vld_r;
  assign stat.count     = count_r;

  // result of an item that needs no edge walk
  always_comb begin
    imm              = '0;
    imm.vertex_count = count_r;
    count_nxt        = count_r;
    case (in_data.command)
      CMD_CLEAR: begin
        count_nxt        = '0;
        imm.vertex_count = '0;
      end
      CMD_APPEND: begin
        if (not_full) begin
          count_nxt        = count_r + 1'b1;
          imm.vertex_count = count_r + 1'b1;
        end else begin
          imm.status = ST_FULL;
        end
      end
      CMD_QUERY: begin
        imm.status = ST_FEW;
      end
      default: begin
        imm.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[count_r[ADDR_W-1:0]] <= in_data.x;
      mem_y[count_r[ADDR_W-1:0]] <= in_data.y;
    end
    if (ctl.issue) begin
      rx_r <= mem_x[ctl.addr];
      ry_r <= mem_y[ctl.addr];
    end
  end

  always_comb begin
    xlo = (esx_r < eex_r) ? esx_r : eex_r;
    xhi = (esx_r < eex_r) ? eex_r : esx_r;
    ylo = (esy_r < eey_r) ? esy_r : eey_r;
    yhi = (esy_r < eey_r) ? eey_r : esy_r;
  end

  // sign of (ex-sx)(py-sy) - (ey-sy)(qx-sx) for the point and the ray point
  assign cp_pt     = PW'(p1_r) - PW'(p2_r);
  assign cp_ray    = PW'(p1_r) - PW'(p3_r);
  assign pt_zero   = (cp_pt == '0);
  assign pt_neg    = cp_pt[PW-1];
  assign ray_zero  = (cp_ray == '0);
  assign ray_neg   = cp_ray[PW-1];
  assign side_diff = (pt_zero != ray_zero) || (pt_neg != ray_neg);

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      px_r <= in_data.x;
      py_r <= in_data.y;
    end
    if (r_vld_r) begin
      pvx_r <= rx_r;
      pvy_r <= ry_r;
      esx_r <= pvx_r;
      esy_r <= pvy_r;
      eex_r <= rx_r;
      eey_r <= ry_r;
    end
    dx_r   <= DW'(eex_r) - DW'(esx_r);
    dy_r   <= DW'(eey_r) - DW'(esy_r);
    dpx_r  <= DW'(px_r) - DW'(esx_r);
    dpy_r  <= DW'(py_r) - DW'(esy_r);
    drx_r  <= RAY_X - RW'(esx_r);
    d_bx_r <= (px_r >= xlo) && (px_r <= xhi);
    d_by_r <= (py_r >= ylo) && (py_r <= yhi);
    d_yr_r <= (py_r > ylo) && (py_r <= yhi);
    p1_r   <= dx_r * dpy_r;
    p2_r   <= dy_r * dpx_r;
    p3_r   <= dy_r * drx_r;
    p_bx_r <= d_bx_r;
    p_by_r <= d_by_r;
    p_yr_r <= d_yr_r;
    if (ctl.accept) begin
      out_data <= imm;
    end else if (ctl.load) begin
      out_data.inside_res   <= bnd_r || crs_r;
      out_data.on_boundary  <= bnd_r;
      out_data.status       <= ST_OK;
      out_data.vertex_count <= count_r;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      r_vld_r    <= 1'b0;
      r_first_r  <= 1'b0;
      e_vld_r    <= 1'b0;
      d_vld_r    <= 1'b0;
      p_vld_r    <= 1'b0;
      bnd_r      <= 1'b0;
      crs_r      <= 1'b0;
      out_strobe <= 1'b0;
    end else begin
      if (ctl.accept) begin
        count_r <= count_nxt;
      end
      r_vld_r   <= ctl.issue;
      r_first_r <= ctl.first;
      e_vld_r   <= r_vld_r && !r_first_r;
      d_vld_r   <= e_vld_r;
      p_vld_r   <= d_vld_r;
      if (ctl.accept) begin
        bnd_r <= 1'b0;
        crs_r <= 1'b0;
      end else if (p_vld_r) begin
        bnd_r <= bnd_r || (pt_zero && p_bx_r && p_by_r);
        crs_r <= crs_r ^ (side_diff && p_yr_r);
      end
      out_strobe <= (ctl.accept && !stat.walk_req) || ctl.load;
    end
  end

endmodule

// File: hdl/point_in_polygon_test.sv
// Point-in-polygon test, top level. Clear, append and unknown commands and
// queries on fewer than three vertices give their result the cycle after the
// transfer. A query on n vertices reads one vertex a cycle (n+1 reads through
// the single store read port), then drains a four-stage edge pipeline; busy is
// high until its result. Reset clears the vertex count; the vertex store itself
// is not cleared.
`timescale 1ns / 1ps

module point_in_polygon_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pip_pkg::pip_in_t  in_data,
  output logic              out_strobe,
  output pip_pkg::pip_out_t out_data
);
  import pip_pkg::*;

  pip_ctl_t  ctl;
  pip_stat_t stat;

  pip_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .ctl   (ctl)
  );

  pip_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .ctl        (ctl),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

endmodule

// File: hdl/pip_chk.sv
// Port-level assertions for the point-in-polygon test, bound to the top
// level. Uses pip_pkg.
`timescale 1ns / 1ps

module pip_chk (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input pip_pkg::pip_in_t  in_data,
  input logic              out_strobe,
  input pip_pkg::pip_out_t out_data
);
  import pip_pkg::*;

  a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command != CMD_QUERY) |=> (out_strobe && !busy))
    else $error("non-query transfer gave no result next cycle");

  a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |=> !busy)
    else $error("busy rose without a transfer");

  a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("query finished without a result");

  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (!busy && out_data.vertex_count <= CNT_W'(MAX_VERTICES)))
    else $error("result during a walk or count out of range");

  a_boundary_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.on_boundary) |-> out_data.inside_res)
    else $error("boundary point not reported inside");

endmodule

bind point_in_polygon_test pip_chk u_pip_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
